### sv/quoted_argument_line_tokenizer_macros.svh
// assertion macros used by the checker file
// each macro samples on clock and is disabled while reset is high
`ifndef QUOTED_ARGUMENT_LINE_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define QALTOK_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed: label");

// next-cycle implication
`define QALTOK_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed: label");

`endif

### sv/qaltok_pkg.sv
// ----------------------------------------------------------------------------
// qaltok_pkg
// Types, character codes and small helpers for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qaltok_pkg;

   typedef enum logic [2:0] {
      MODE_SKIP  = 3'b001,
      MODE_WORD  = 3'b010,
      MODE_QUOTE = 3'b100
   } scan_mode_type;

   localparam logic [7:0] CSR_LINE_CAPACITY = 8'd0;
   localparam logic [7:0] CSR_ARG_CAPACITY  = 8'd1;

   localparam logic [12:0] LINE_CAPACITY_RESET = 13'd4096;
   localparam logic [7:0]  ARG_CAPACITY_RESET  = 8'd128;

   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_VT        = 8'h0B;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_BEL       = 8'h07;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_V   = 8'h76;

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CHAR_LOWER_A: r = CHAR_BEL;
         CHAR_LOWER_B: r = CHAR_BS;
         CHAR_LOWER_F: r = CHAR_FF;
         CHAR_LOWER_R: r = CHAR_CR;
         CHAR_LOWER_N: r = CHAR_LF;
         CHAR_LOWER_V: r = CHAR_VT;
         default:      r = c;
      endcase
      return r;
   endfunction

endpackage

### sv/quoted_argument_line_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_argument_line_tokenizer
// Splits a byte stream into lines of quoted, escaped, NUL-separated arguments.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | in_byte, end_of_input
//  rsp     | out | rsp_valid/rsp_ready   | out_byte, arg_start, write_index,
//          |     |                       | line_end, arg_total, input_ended
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata
//
// one byte is taken per cycle while req_ready is high; its result word, if any, shows the next cycle
// the scan state updates in the same cycle, so throughput is one byte a clock while the output is not stalled
// req_ready is high whenever the result register is empty or being drained
// synchronous reset clears the scan state and the result valid flag and loads the csr reset values
// csr writes are always taken
module quoted_argument_line_tokenizer
   import qaltok_pkg::*;
#(
   parameter int MAX_LINE_BYTES = 4096,
   parameter int MAX_ARGS       = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_arg_start,
   output logic [11:0] rsp_write_index,
   output logic        rsp_line_end,
   output logic [6:0]  rsp_arg_total,
   output logic        rsp_input_ended,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int FW  = $clog2(MAX_LINE_BYTES);
   localparam int LWR = $clog2(MAX_LINE_BYTES + 1);
   localparam int LW  = (LWR > 13) ? LWR : 13;
   localparam int AW  = $clog2(MAX_ARGS);
   localparam int AWR = $clog2(MAX_ARGS + 1);
   localparam int AL  = (AWR > 8) ? AWR : 8;

   // csrs
   logic [12:0] line_capacity_ff;
   logic [7:0]  arg_capacity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_capacity_ff <= LINE_CAPACITY_RESET;
         arg_capacity_ff  <= ARG_CAPACITY_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_LINE_CAPACITY) begin
            line_capacity_ff <= csr_wdata[12:0];
         end else if (csr_index == CSR_ARG_CAPACITY) begin
            arg_capacity_ff <= csr_wdata[7:0];
         end
      end
   end

   // scan state
   scan_mode_type   mode_ff, mode_in;
   logic            comment_ff, comment_in;
   logic            esc_ff, esc_in;
   logic            esc_skip_ff, esc_skip_in;
   logic            start_ff, start_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [AW-1:0]   arg_ff, arg_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      out_byte_ff;
   logic            arg_start_ff;
   logic [11:0]     write_index_ff;
   logic            line_end_ff;
   logic [6:0]      arg_total_ff;
   logic            input_ended_ff;

   logic            accept;
   logic            emit;
   logic [7:0]      emit_byte;
   logic            emit_last;
   logic            emit_ended;
   logic            emit_start;
   logic            in_word_or_quote;
   logic            limit_hit;
   logic [LW-1:0]   lcap;
   logic [LW-1:0]   fill_plus1;
   logic [AL-1:0]   acap;
   logic [AL-1:0]   arg_plus2;
   logic [31:0]     fill_wide;
   logic [31:0]     arg_wide;
   logic [7:0]      c;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign c         = req_in_byte;

   // clamp capacities to the buffer size
   always_comb begin
      lcap = (LW'(line_capacity_ff) < LW'(MAX_LINE_BYTES)) ?
             LW'(line_capacity_ff) : LW'(MAX_LINE_BYTES);
      acap = (AL'(arg_capacity_ff) < AL'(MAX_ARGS)) ?
             AL'(arg_capacity_ff) : AL'(MAX_ARGS);
      fill_plus1 = LW'(fill_ff) + LW'(1);
      arg_plus2  = AL'(arg_ff) + AL'(2);
      limit_hit  = (fill_plus1 >= lcap) || (arg_plus2 >= acap);
   end

   always_comb begin
      mode_in     = mode_ff;
      comment_in  = comment_ff;
      esc_in      = esc_ff;
      esc_skip_in = esc_skip_ff;
      start_in    = start_ff;
      fill_in     = fill_ff;
      arg_in      = arg_ff;
      emit        = 1'b0;
      emit_byte   = 8'h00;
      emit_last   = 1'b0;
      emit_ended  = 1'b0;
      in_word_or_quote = (mode_ff == MODE_WORD) || (mode_ff == MODE_QUOTE);

      if (req_end_of_input) begin
         emit       = 1'b1;
         emit_last  = 1'b1;
         emit_ended = 1'b1;
      end else if (comment_ff) begin
         if (c == CHAR_LF) begin
            emit      = 1'b1;
            emit_last = 1'b1;
         end
      end else if (esc_ff) begin
         if (c != CHAR_CR) begin
            esc_in = 1'b0;
            if (c == CHAR_LF) begin
               // line continuation
               esc_skip_in = 1'b0;
            end else begin
               if (esc_skip_ff) begin
                  esc_skip_in = 1'b0;
                  arg_in      = AW'(arg_ff + AW'(1));
                  start_in    = 1'b1;
                  mode_in     = MODE_WORD;
               end
               emit      = 1'b1;
               emit_byte = escape_map(c);
            end
         end
      end else if (limit_hit) begin
         emit      = 1'b1;
         emit_last = 1'b1;
      end else if (mode_ff != MODE_QUOTE && c == CHAR_HASH) begin
         comment_in = 1'b1;
      end else if (c == CHAR_LF) begin
         emit      = 1'b1;
         emit_last = 1'b1;
      end else if (c == CHAR_CR) begin
         // carriage returns dropped
      end else if (!in_word_or_quote && is_blank(c)) begin
         // leading blank
      end else if (!in_word_or_quote && c == CHAR_BACKSLASH) begin
         esc_in      = 1'b1;
         esc_skip_in = 1'b1;
      end else begin
         if (!in_word_or_quote) begin
            arg_in   = AW'(arg_ff + AW'(1));
            start_in = 1'b1;
            mode_in  = MODE_WORD;
         end
         if (c == CHAR_BACKSLASH) begin
            esc_in      = 1'b1;
            esc_skip_in = 1'b0;
         end else if (c == CHAR_QUOTE) begin
            mode_in = (mode_ff == MODE_QUOTE) ? MODE_WORD : MODE_QUOTE;
         end else if (mode_in == MODE_WORD && is_blank(c)) begin
            mode_in = MODE_SKIP;
            emit    = 1'b1;
         end else begin
            emit      = 1'b1;
            emit_byte = c;
         end
      end

      // start flag seen by the written word includes this cycle's update
      emit_start = start_in;

      if (emit) begin
         start_in = 1'b0;
         if (emit_last) begin
            mode_in     = MODE_SKIP;
            comment_in  = 1'b0;
            esc_in      = 1'b0;
            esc_skip_in = 1'b0;
            fill_in     = '0;
            arg_in      = '0;
         end else begin
            fill_in = FW'(fill_ff + FW'(1));
         end
      end
   end

   assign fill_wide = 32'(fill_ff);
   assign arg_wide  = 32'(arg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_SKIP;
         comment_ff  <= 1'b0;
         esc_ff      <= 1'b0;
         esc_skip_ff <= 1'b0;
         start_ff    <= 1'b0;
         fill_ff     <= '0;
         arg_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         comment_ff  <= comment_in;
         esc_ff      <= esc_in;
         esc_skip_ff <= esc_skip_in;
         start_ff    <= start_in;
         fill_ff     <= fill_in;
         arg_ff      <= arg_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_byte_ff    <= emit_byte;
         arg_start_ff   <= emit_start;
         write_index_ff <= fill_wide[11:0];
         line_end_ff    <= emit_last;
         arg_total_ff   <= emit_last ? arg_wide[6:0] : 7'd0;
         input_ended_ff <= emit_ended;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_arg_start   = arg_start_ff;
   assign rsp_write_index = write_index_ff;
   assign rsp_line_end    = line_end_ff;
   assign rsp_arg_total   = arg_total_ff;
   assign rsp_input_ended = input_ended_ff;

endmodule

### sv/qaltok_checker.sv
// ----------------------------------------------------------------------------
// qaltok_checker
// Port-level checks for the quoted argument tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "quoted_argument_line_tokenizer_macros.svh"

module qaltok_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_end_of_input,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_line_end,
   input logic [6:0]  rsp_arg_total,
   input logic        rsp_input_ended
);

   // a stalled result word holds
   `QALTOK_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_line_end))

   // an empty result register never blocks the input
   `QALTOK_ASSERT_IMPLY(ready_when_empty, !rsp_valid, req_ready)

   // count and end flag only on the line terminator
   `QALTOK_ASSERT_IMPLY(tail_fields, rsp_valid && !rsp_line_end, rsp_arg_total == 7'd0 && !rsp_input_ended)

   // end of input always closes a line on the next cycle
   `QALTOK_ASSERT_NEXT(eoi_closes, req_valid && req_ready && req_end_of_input, rsp_valid && rsp_line_end && rsp_input_ended && rsp_out_byte == 8'h00)

endmodule

bind quoted_argument_line_tokenizer qaltok_checker u_qaltok_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_end_of_input(req_end_of_input),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_line_end    (rsp_line_end),
   .rsp_arg_total   (rsp_arg_total),
   .rsp_input_ended (rsp_input_ended)
);
